[hdl/srcnt_pkg.sv]
package srcnt_pkg;

	localparam int MAX_PARTICLES = 64;
	localparam int WEIGHT_BITS   = 16;

	localparam int IDX_W  = $clog2(MAX_PARTICLES);
	localparam int SUM_W  = WEIGHT_BITS + IDX_W;
	localparam int SCNT_W = 7;
	localparam int CNT_W  = 7;
	localparam int PROD_W = SUM_W + SCNT_W;

	localparam int S_TDATA_W = ((WEIGHT_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((IDX_W + CNT_W + 7) / 8) * 8;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [SCNT_W-1:0] SCNT_RESET = SCNT_W'(64);

	// register index, taken from the word-address bit of paddr
	localparam logic REG_SAMPLE_COUNT = 1'b0;

	typedef struct packed {
		logic             load;
		logic [IDX_W-1:0] load_idx;
		logic             shift;
	} chain_ctl_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] total;
		logic [IDX_W-1:0] nlast;
	} run_req_t;

endpackage

[hdl/srcnt_cell.sv]
module srcnt_cell (
	input  logic                        clk,
	input  srcnt_pkg::chain_ctl_t       ctl,
	input  logic [srcnt_pkg::IDX_W-1:0] cell_idx,
	input  logic [srcnt_pkg::SUM_W-1:0] load_sum,
	input  logic [srcnt_pkg::SUM_W-1:0] next_sum,
	output logic [srcnt_pkg::SUM_W-1:0] sum
);
	import srcnt_pkg::*;

	logic [SUM_W-1:0] sum_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (ctl.load && ctl.load_idx == cell_idx) begin
			sum_q <= load_sum;
		end else if (ctl.shift) begin
			sum_q <= next_sum;
		end
	end

	assign sum = sum_q;

endmodule

[hdl/srcnt_chain.sv]
module srcnt_chain (
	input  logic                        clk,
	input  srcnt_pkg::chain_ctl_t       ctl,
	input  logic [srcnt_pkg::SUM_W-1:0] load_sum,
	output logic [srcnt_pkg::SUM_W-1:0] head_sum,
	output logic [srcnt_pkg::SUM_W-1:0] next_head_sum
);
	import srcnt_pkg::*;

	logic [SUM_W-1:0] sums [MAX_PARTICLES];

	// cells shift toward cell 0; the top cell pulls in zero
	for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_cell
		logic [SUM_W-1:0] nxt;
		if (k == MAX_PARTICLES - 1) begin : g_top
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = sums[k+1];
		end
		srcnt_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.cell_idx (IDX_W'(k)),
			.load_sum (load_sum),
			.next_sum (nxt),
			.sum      (sums[k])
		);
	end

	assign head_sum      = sums[0];
	assign next_head_sum = sums[1];

endmodule

[hdl/srcnt_walker.sv]
module srcnt_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  srcnt_pkg::run_req_t          req,
	input  logic [srcnt_pkg::SCNT_W-1:0] sample_count,
	input  logic [srcnt_pkg::SUM_W-1:0]  head_sum,
	input  logic [srcnt_pkg::SUM_W-1:0]  next_head_sum,
	output logic                         shift,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [srcnt_pkg::IDX_W-1:0]  out_idx,
	output logic [srcnt_pkg::CNT_W-1:0]  out_count,
	output logic                         out_last
);
	import srcnt_pkg::*;

	typedef enum logic [1:0] {
		W_IDLE,
		W_START,
		W_WALK
	} wstate_t;

	wstate_t           state_q;
	logic [SUM_W-1:0]  total_q;
	logic [IDX_W-1:0]  nlast_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [SCNT_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] lhs_q;
	logic [PROD_W-1:0] prod_q;
	logic              ov_q;
	logic [IDX_W-1:0]  oidx_q;
	logic [CNT_W-1:0]  ocnt_q;
	logic              olast_q;

	logic              at_last;
	logic              take;
	logic              slot_free;
	logic              emit;
	logic [SUM_W-1:0]  mul_in;
	logic [PROD_W-1:0] prod_d;

	assign at_last   = (ptr_q == nlast_q);
	// point lands on the current particle, or on the last one when the search runs out
	assign take      = (rem_q != '0) && ((lhs_q < prod_q) || at_last);
	assign slot_free = !ov_q || out_ready;
	// current particle is done and its count goes to the result register
	assign emit      = (state_q == W_WALK) && !take && slot_free;
	assign shift     = emit && !at_last;
	assign busy      = (state_q != W_IDLE);

	assign mul_in = (state_q == W_START) ? head_sum : next_head_sum;
	assign prod_d = PROD_W'(sample_count) * PROD_W'(mul_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			ov_q    <= 1'b0;
			ptr_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			lhs_q   <= '0;
			prod_q  <= '0;
			oidx_q  <= '0;
			ocnt_q  <= '0;
			olast_q <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				W_IDLE: begin
					if (req.start) begin
						state_q <= W_START;
					end
				end
				W_START: begin
					prod_q  <= prod_d;
					lhs_q   <= PROD_W'(total_q);
					rem_q   <= sample_count;
					ptr_q   <= '0;
					cnt_q   <= '0;
					state_q <= W_WALK;
				end
				W_WALK: begin
					if (take) begin
						cnt_q <= cnt_q + CNT_W'(1);
						rem_q <= rem_q - SCNT_W'(1);
						lhs_q <= lhs_q + PROD_W'(total_q);
					end else if (slot_free) begin
						oidx_q  <= ptr_q;
						ocnt_q  <= cnt_q;
						olast_q <= at_last;
						if (at_last) begin
							state_q <= W_IDLE;
						end else begin
							ptr_q  <= ptr_q + IDX_W'(1);
							cnt_q  <= '0;
							prod_q <= prod_d;
						end
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && req.start) begin
			total_q <= req.total;
			nlast_q <= req.nlast;
		end
	end

	assign out_valid = ov_q;
	assign out_idx   = oidx_q;
	assign out_count = ocnt_q;
	assign out_last  = olast_q;

endmodule

[hdl/systematic_resampling_counts_core.sv]
// Flow: a set of N weights loads at one weight per cycle while the walker is idle; the closing
//   weight moves the walker to W_START and then W_WALK, which deals S points (S = sample_count)
//   over N particles, one point or one particle per cycle while the result side does not stall.
// Sets: no new set loads until the walk ends; bounded by the single compare/multiply walker.
// Reset: arst_n clears control state and sets sample_count to 64; the sum cells carry no reset.
module systematic_resampling_counts_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [srcnt_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] weight
	input  logic                             s_tlast,   // last_weight
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [srcnt_pkg::M_TDATA_W-1:0]  m_tdata,   // [5:0] particle_index, [12:6] copy_count
	output logic                             m_tlast,   // last_count
	// register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [srcnt_pkg::ADDR_W-1:0]     paddr,
	input  logic [srcnt_pkg::DATA_W-1:0]     pwdata,
	output logic [srcnt_pkg::DATA_W-1:0]     prdata,
	output logic                             pready
);
	import srcnt_pkg::*;

	logic [SCNT_W-1:0] sample_count_q;
	logic [SUM_W-1:0]  acc_q;        // running sum of the set being loaded
	logic [IDX_W-1:0]  load_cnt_q;   // slot of the next weight

	chain_ctl_t        chain_ctl;
	run_req_t          run_req;
	logic              in_req;
	logic              closing;
	logic [SUM_W-1:0]  sum_new;
	logic [SUM_W-1:0]  head_sum;
	logic [SUM_W-1:0]  next_head_sum;
	logic              walk_shift;
	logic              busy;
	logic [IDX_W-1:0]  out_idx;
	logic [CNT_W-1:0]  out_count;

	// ---------------- register port ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_SAMPLE_COUNT) ? DATA_W'(sample_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SCNT_RESET;
		end else if (psel && penable && pwrite && pready
		             && paddr[ADDR_W-1] == REG_SAMPLE_COUNT) begin
			sample_count_q <= pwdata[SCNT_W-1:0];
		end
	end

	// ---------------- weight loading ----------------
	// weights are taken only while the walker is idle; the result register may
	// still hold the final count of the previous set
	assign s_tready = !busy;
	assign in_req   = s_tvalid && s_tready;
	assign sum_new  = acc_q + SUM_W'(s_tdata[WEIGHT_BITS-1:0]);
	// a full chain closes the set even without tlast
	assign closing  = s_tlast || (load_cnt_q == IDX_W'(MAX_PARTICLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			load_cnt_q <= '0;
		end else if (in_req) begin
			if (closing) begin
				acc_q      <= '0;
				load_cnt_q <= '0;
			end else begin
				acc_q      <= sum_new;
				load_cnt_q <= load_cnt_q + IDX_W'(1);
			end
		end
	end

	assign chain_ctl.load     = in_req;
	assign chain_ctl.load_idx = load_cnt_q;
	assign chain_ctl.shift    = walk_shift;

	assign run_req.start = in_req && closing;
	assign run_req.total = sum_new;
	assign run_req.nlast = load_cnt_q;

	// ---------------- cell row of running sums ----------------
	srcnt_chain u_chain (
		.clk           (clk),
		.ctl           (chain_ctl),
		.load_sum      (sum_new),
		.head_sum      (head_sum),
		.next_head_sum (next_head_sum)
	);

	// ---------------- merge walk of points against particles ----------------
	// compare is (i+1)*total < S*running_sum; (i+1)*total advances by adding total, S*running_sum
	// comes from the head cell at start, then is formed one particle ahead from the second cell of the row
	srcnt_walker u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (run_req),
		.sample_count  (sample_count_q),
		.head_sum      (head_sum),
		.next_head_sum (next_head_sum),
		.shift         (walk_shift),
		.busy          (busy),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_idx       (out_idx),
		.out_count     (out_count),
		.out_last      (m_tlast)
	);

	assign m_tdata = M_TDATA_W'({out_count, out_idx});

	// ---------------- checks ----------------
	a_no_shift_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(chain_ctl.shift && chain_ctl.load))
		else $error("chain shift during a weight load");

	a_close_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		run_req.start |=> busy)
		else $error("closing weight did not start the walk");

	a_idle_no_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !walk_shift)
		else $error("chain shifted while walker idle");

endmodule

[tb/tb_systematic_resampling_counts_core.sv]
module tb_systematic_resampling_counts_core;
	import srcnt_pkg::*;

	// register map: one register, word address bit selects the index
	localparam logic [ADDR_W-1:0] ADDR_SAMPLE_COUNT = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED     = ADDR_W'(4);

	// weight requests sent by the random test
	localparam int RANDOM_ITEMS = 256;

	// weight patterns for a set
	typedef enum int {
		W_FULL,
		W_SMALL,
		W_ZERO,
		W_EXTREME,
		W_SPARSE
	} weight_mode_t;

	typedef struct {
		logic [IDX_W-1:0] particle_index;
		logic [CNT_W-1:0] copy_count;
		logic             last_count;
	} count_rec_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;   // [15:0] weight
	logic                 s_tlast  = 1'b0; // last_weight
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;         // [5:0] particle_index, [12:6] copy_count
	logic                 m_tlast;         // last_count
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [ADDR_W-1:0]    paddr    = '0;
	logic [DATA_W-1:0]    pwdata   = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	// predictor state
	logic [SUM_W-1:0]  cum_weight [MAX_PARTICLES];
	int unsigned       weights_held;
	logic [SCNT_W-1:0] points_per_set;
	count_rec_t        expected_counts [$];

	// bookkeeping
	int  mismatches     = 0;
	int  counts_checked = 0;
	int  sets_closed    = 0;
	int  sent_requests  = 0;
	int  random_requests = 0;
	bit  idle_on        = 1'b1;
	int  stall_left     = 0;
	count_rec_t want_rec;

	systematic_resampling_counts_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH @%0t %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Accumulate one weight; on a closing weight, deal the points over the set
	// and queue one count per particle.
	function automatic void predict_weight(logic [WEIGHT_BITS-1:0] weight, logic last);
		longint unsigned total;
		longint unsigned span;
		longint unsigned pos;
		int unsigned     ptr;
		int unsigned     n;
		logic [CNT_W-1:0] copies [MAX_PARTICLES];
		count_rec_t      rec;

		if (weights_held >= MAX_PARTICLES)
			weights_held = 0;
		cum_weight[weights_held] = (weights_held == 0) ? SUM_W'(weight)
			: cum_weight[weights_held-1] + SUM_W'(weight);
		weights_held++;
		// set closes on tlast or when the particle table is full
		if (!last && weights_held < MAX_PARTICLES)
			return;

		n     = weights_held;
		total = cum_weight[n-1];
		span  = points_per_set;
		ptr   = 0;
		foreach (copies[k])
			copies[k] = '0;
		// point i sits at (i+1)*total/S; compare cross-multiplied, no division
		for (longint unsigned i = 0; i < span; i++) begin
			pos = (i + 1) * total;
			while (!(pos < span * cum_weight[ptr]) && ptr < n - 1)
				ptr++;
			copies[ptr] = copies[ptr] + 1'b1;
		end
		for (int unsigned k = 0; k < n; k++) begin
			rec.particle_index = IDX_W'(k);
			rec.copy_count     = copies[k];
			rec.last_count     = (k == n - 1);
			expected_counts.insert(expected_counts.size(), rec);
		end
		weights_held = 0;
		sets_closed++;
	endfunction

	// Result checker: every accepted count against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			counts_checked++;
			if (expected_counts.size() == 0) begin
				report_mismatch("count with none expected, index", m_tdata[IDX_W-1:0], -1);
			end else begin
				want_rec = expected_counts.pop_front();
				if (m_tdata[IDX_W-1:0] !== want_rec.particle_index)
					report_mismatch("particle_index", m_tdata[IDX_W-1:0],
						want_rec.particle_index);
				if (m_tdata[IDX_W+CNT_W-1:IDX_W] !== want_rec.copy_count)
					report_mismatch("copy_count", m_tdata[IDX_W+CNT_W-1:IDX_W],
						want_rec.copy_count);
				if (m_tlast !== want_rec.last_count)
					report_mismatch("last_count", m_tlast, want_rec.last_count);
				if (m_tdata[M_TDATA_W-1:IDX_W+CNT_W] !== '0)
					report_mismatch("tdata padding", m_tdata[M_TDATA_W-1:IDX_W+CNT_W], 0);
			end
		end
	end

	// Result-side backpressure: random stall bursts while idling is on.
	always @(posedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// One weight request; valid stays up between back-to-back requests.
	task automatic send_weight(logic [WEIGHT_BITS-1:0] weight, logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'(weight);
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		predict_weight(weight, last);
		sent_requests++;
	endtask

	// Hold off new requests until every queued count is out, then let the walker settle.
	task automatic drain_counts();
		s_tvalid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_SAMPLE_COUNT)
			points_per_set = value[SCNT_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read_check();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_SAMPLE_COUNT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[SCNT_W-1:0] !== points_per_set)
			report_mismatch("sample_count readback", prdata[SCNT_W-1:0], points_per_set);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// register write while idle: drain first, then write
	task automatic set_points(int unsigned s);
		logic [DATA_W-1:0] value;

		drain_counts();
		value = $urandom();
		value[SCNT_W-1:0] = SCNT_W'(s);
		reg_write(ADDR_SAMPLE_COUNT, value);
		reg_read_check();
	endtask

	function automatic logic [WEIGHT_BITS-1:0] pick_weight(weight_mode_t mode);
		case (mode)
			W_FULL:    return WEIGHT_BITS'($urandom());
			W_SMALL:   return WEIGHT_BITS'($urandom_range(0, 3));
			W_ZERO:    return '0;
			W_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
			default:   return ($urandom_range(0, 2) == 0) ? WEIGHT_BITS'($urandom()) : '0;
		endcase
	endfunction

	// A set of len weights; without close the table-full rule ends a 64-weight set.
	task automatic send_set(int unsigned len, bit close, weight_mode_t mode);
		for (int unsigned i = 0; i < len; i++)
			send_weight(pick_weight(mode), close && (i == len - 1));
	endtask

	// --- directed tests ---

	// reset value of sample_count, and a plain set dealt with 64 points
	task automatic test_reset_default();
		reg_read_check();
		send_weight(16'd3, 1'b0);
		send_weight(16'd1, 1'b0);
		send_weight(16'd7, 1'b0);
		send_weight(16'd5, 1'b1);
	endtask

	// largest and smallest weights side by side
	task automatic test_weight_extremes();
		send_weight(16'hFFFF, 1'b0);
		send_weight(16'h0000, 1'b0);
		send_weight(16'hFFFF, 1'b0);
		send_weight(16'h0001, 1'b1);
	endtask

	// zero total: nothing passes the compare, all points land on the last particle
	task automatic test_zero_total();
		send_set(3, 1'b1, W_ZERO);
	endtask

	// one-particle set takes every point
	task automatic test_single_particle();
		send_weight(16'd42, 1'b1);
	endtask

	// no points, one point, and the widest point count the register holds
	task automatic test_point_count_extremes();
		set_points(0);
		send_weight(16'd9, 1'b0);
		send_weight(16'hFFFF, 1'b0);
		send_weight(16'd2, 1'b1);
		set_points(1);
		send_weight(16'd1, 1'b0);
		send_weight(16'd1, 1'b0);
		send_weight(16'd1, 1'b1);
		set_points(127);
		send_weight(16'hFFFF, 1'b0);
		send_weight(16'd0, 1'b0);
		send_weight(16'h8000, 1'b0);
		send_weight(16'h7FFF, 1'b1);
	endtask

	// write to an unmapped register must not touch sample_count
	task automatic test_unmapped_write();
		drain_counts();
		reg_write(ADDR_UNMAPPED, 32'h0000_0005);
		reg_read_check();
		send_weight(16'd10, 1'b0);
		send_weight(16'd30, 1'b1);
	endtask

	// --- random test ---

	// Phases of one point count each; set lengths mostly short, some full-table
	// sets closed by the size limit alone. Idling stops for the tail of the run.
	task automatic test_random_sets();
		int unsigned  sets;
		int unsigned  len;
		bit           close;
		weight_mode_t mode;

		while (random_requests < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0:       set_points(0);
				1:       set_points(1);
				2:       set_points(127);
				3:       set_points(64);
				default: set_points($urandom_range(1, 127));
			endcase
			if ($urandom_range(0, 5) == 0) begin
				reg_write(ADDR_UNMAPPED, $urandom());
				reg_read_check();
			end
			sets = $urandom_range(1, 4);
			for (int unsigned k = 0; k < sets && random_requests < RANDOM_ITEMS; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 8);
					7, 8:                len = $urandom_range(9, 32);
					default:             len = MAX_PARTICLES;
				endcase
				// keep the request total on target
				if (len > RANDOM_ITEMS - random_requests)
					len = RANDOM_ITEMS - random_requests;
				close = (len < MAX_PARTICLES) || ($urandom_range(0, 1) != 0);
				case ($urandom_range(0, 9))
					0:       mode = W_ZERO;
					1:       mode = W_SMALL;
					2:       mode = W_EXTREME;
					3:       mode = W_SPARSE;
					default: mode = W_FULL;
				endcase
				idle_on = (random_requests < RANDOM_ITEMS - 60);
				send_set(len, close, mode);
				random_requests += len;
			end
		end
	endtask

	initial begin
		weights_held   = 0;
		points_per_set = SCNT_RESET;
		foreach (cum_weight[k])
			cum_weight[k] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_default();
		test_weight_extremes();
		test_zero_total();
		test_single_particle();
		test_point_count_extremes();
		test_unmapped_write();
		test_random_sets();

		drain_counts();
		repeat (20) @(posedge clk);
		$display("Run covered %0d weight requests in %0d sets, %0d counts checked.",
			sent_requests, sets_closed, counts_checked);
		$display("Point counts 0..127, zero totals, single particles and full-table sets.");
		if (mismatches == 0 && expected_counts.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d counts still expected", expected_counts.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[filelist.f]
hdl/srcnt_pkg.sv
hdl/srcnt_cell.sv
hdl/srcnt_chain.sv
hdl/srcnt_walker.sv
hdl/systematic_resampling_counts_core.sv
tb/tb_systematic_resampling_counts_core.sv
